FILE: rtl/core/cfd_pkg.sv
`timescale 1ns / 1ps

package cfd_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CfgAddrW   = 4;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_TICK  = 2'd1,
    OP_NMT   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_OWN_NODE = 2'd1,
    CFG_TIMEOUT  = 2'd2,
    CFG_PERIOD   = 2'd3
  } cfg_idx_e;

  localparam logic [10:0] FC_MASK      = 11'h780;
  localparam logic [10:0] FC_RPDO1     = 11'h200;
  localparam logic [10:0] FC_HEARTBEAT = 11'h700;
  localparam logic [10:0] FC_EMCY      = 11'h080;

  localparam logic [7:0] CMD_START      = 8'h01;
  localparam logic [7:0] CMD_STOP       = 8'h02;
  localparam logic [7:0] CMD_PREOP      = 8'h80;
  localparam logic [7:0] CMD_RESET_NODE = 8'h81;
  localparam logic [7:0] CMD_RESET_COMM = 8'h82;

  localparam logic [6:0] ST_INIT    = 7'd0;
  localparam logic [6:0] ST_STOPPED = 7'd4;
  localparam logic [6:0] ST_OPER    = 7'd5;
  localparam logic [6:0] ST_PREOP   = 7'd127;

  localparam logic [15:0] ERR_COMM = 16'h5000;
  localparam logic [15:0] CNT_SAT  = 16'hFFFF;

  localparam logic [15:0] TIMEOUT_RST = 16'd300;
  localparam logic [15:0] PERIOD_RST  = 16'd100;
  localparam logic [6:0]  NODE_RST    = 7'd1;

  typedef enum logic [2:0] {
    K_NONE,
    K_RPDO,
    K_HB,
    K_EMCY,
    K_REJECT,
    K_TICK,
    K_NMT
  } kind_e;

  // Classified request handed from the front to the back
  typedef struct packed {
    kind_e       kind;
    logic [31:0] data;
    logic        state_set;
    logic [6:0]  state_val;
    logic [7:0]  command;
    logic [6:0]  target;
  } item_t;

  typedef struct packed {
    logic        enable;
    logic [6:0]  own_node;
    logic [15:0] timeout;
    logic [15:0] period;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] velocity_setpoint;
    logic [6:0]         node_mode;
    logic [15:0]        emergency_code;
    logic [7:0]         fault_flags;
    logic               heartbeat_timeout;
    logic               frame_rejected;
    logic               tx_valid;
    logic [10:0]        tx_can_id;
    logic [7:0]         tx_byte0;
    logic [7:0]         tx_byte1;
  } result_t;

endpackage

FILE: rtl/core/cfd_front.sv
`timescale 1ns / 1ps

module cfd_front import cfd_pkg::*; (
  input  logic        enable_i,
  input  logic [1:0]  operation_i,
  input  logic [10:0] can_id_i,
  input  logic [3:0]  dlc_i,
  input  logic [31:0] payload_i,
  input  logic [7:0]  command_i,
  input  logic [6:0]  target_node_i,
  output item_t       item_o
);

  logic [10:0] fc;

  assign fc = can_id_i & FC_MASK;

  always_comb begin
    item_o           = '0;
    item_o.kind      = K_NONE;
    item_o.data      = payload_i;
    item_o.command   = command_i;
    item_o.target    = target_node_i;
    item_o.state_val = payload_i[6:0];
    unique case (op_e'(operation_i))
      OP_FRAME: begin
        if (enable_i) begin
          unique case (fc)
            FC_RPDO1: item_o.kind = K_RPDO;
            FC_HEARTBEAT: begin
              item_o.kind      = K_HB;
              item_o.state_set = payload_i[7:0] inside {{1'b0, ST_STOPPED},
                                                        {1'b0, ST_OPER},
                                                        {1'b0, ST_PREOP}};
            end
            FC_EMCY: item_o.kind = (dlc_i < 4'd4) ? K_REJECT : K_EMCY;
            default: item_o.kind = K_NONE;
          endcase
        end
      end
      OP_TICK: begin
        if (enable_i) begin
          item_o.kind = K_TICK;
        end
      end
      OP_NMT: begin
        item_o.kind = K_NMT;
        unique case (command_i) inside
          CMD_START: begin
            item_o.state_set = 1'b1;
            item_o.state_val = ST_OPER;
          end
          CMD_STOP: begin
            item_o.state_set = 1'b1;
            item_o.state_val = ST_STOPPED;
          end
          CMD_PREOP: begin
            item_o.state_set = 1'b1;
            item_o.state_val = ST_PREOP;
          end
          CMD_RESET_NODE, CMD_RESET_COMM: begin
            item_o.state_set = 1'b1;
            item_o.state_val = ST_INIT;
          end
          default: item_o.state_set = 1'b0;
        endcase
      end
      default: item_o.kind = K_NONE;
    endcase
  end

endmodule

FILE: rtl/core/cfd_queue.sv
`timescale 1ns / 1ps

// DEPTH must be at least 2
module cfd_queue import cfd_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  item_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_wr, do_rd;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/cfd_back.sv
`timescale 1ns / 1ps

module cfd_back import cfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  logic    item_empty_i,
  output logic    item_pop_o,
  output result_t res_o,
  output logic    res_empty_o,
  input  logic    res_pop_i
);

  logic [6:0]  node_state_q, node_state_d;
  logic        armed_q, armed_d;
  logic [15:0] since_hb_q, since_hb_d;
  logic [15:0] since_sent_q, since_sent_d;
  logic [15:0] err_code_q, err_code_d;
  logic [7:0]  err_bits_q, err_bits_d;
  logic [31:0] velocity_q, velocity_d;
  logic        res_valid_q;
  result_t     res_q, res_d;
  logic        advance;
  logic [15:0] sent_inc, hb_inc;

  // Take the next request when the result slot is free or drains now
  assign advance     = !item_empty_i && (!res_valid_q || res_pop_i);
  assign item_pop_o  = advance;
  assign res_empty_o = !res_valid_q;
  assign res_o       = res_q;

  assign sent_inc = (since_sent_q == CNT_SAT) ? CNT_SAT : since_sent_q + 16'd1;
  assign hb_inc   = (since_hb_q == CNT_SAT) ? CNT_SAT : since_hb_q + 16'd1;

  always_comb begin
    node_state_d = node_state_q;
    armed_d      = armed_q;
    since_hb_d   = since_hb_q;
    since_sent_d = since_sent_q;
    err_code_d   = err_code_q;
    err_bits_d   = err_bits_q;
    velocity_d   = velocity_q;
    res_d        = '0;
    case (item_i.kind)
      K_RPDO: velocity_d = item_i.data;
      K_HB: begin
        since_hb_d = '0;
        armed_d    = 1'b1;
        if (item_i.state_set) begin
          node_state_d = item_i.state_val;
        end
      end
      K_EMCY: begin
        err_code_d = item_i.data[15:0];
        err_bits_d = err_bits_q | item_i.data[23:16];
      end
      K_REJECT: res_d.frame_rejected = 1'b1;
      K_TICK: begin
        since_sent_d = sent_inc;
        since_hb_d   = hb_inc;
        if (node_state_q == ST_OPER && sent_inc >= cfg_i.period) begin
          res_d.tx_valid  = 1'b1;
          res_d.tx_can_id = FC_HEARTBEAT | {4'd0, cfg_i.own_node};
          res_d.tx_byte0  = {1'b0, node_state_q};
          since_sent_d    = '0;
        end
        if (armed_q && hb_inc > cfg_i.timeout) begin
          res_d.heartbeat_timeout = 1'b1;
          err_code_d              = ERR_COMM;
        end
      end
      K_NMT: begin
        res_d.tx_valid  = 1'b1;
        res_d.tx_byte0  = item_i.command;
        res_d.tx_byte1  = {1'b0, item_i.target};
        if (item_i.state_set) begin
          node_state_d = item_i.state_val;
        end
      end
      default: ;
    endcase
    res_d.velocity_setpoint = velocity_d;
    res_d.node_mode         = node_state_d;
    res_d.emergency_code    = err_code_d;
    res_d.fault_flags       = err_bits_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_state_q <= ST_INIT;
      armed_q      <= 1'b0;
      since_hb_q   <= '0;
      since_sent_q <= CNT_SAT;
      err_code_q   <= '0;
      err_bits_q   <= '0;
      velocity_q   <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        node_state_q <= node_state_d;
        armed_q      <= armed_d;
        since_hb_q   <= since_hb_d;
        since_sent_q <= since_sent_d;
        err_code_q   <= err_code_d;
        err_bits_q   <= err_bits_d;
        velocity_q   <= velocity_d;
        res_valid_q  <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

endmodule

FILE: rtl/core/canopen_frame_dispatch_heartbeat.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Contents
// request   in         push / full            operation, frame, NMT command
// result    out        pop / empty            status, flags, frame to transmit
// config    in         psel/penable/pwrite    enable, node id, timeout, period
//
// One request per cycle sustained while results are popped; a result reaches the result
// ports through the request queue (classified and written at the edge that accepts
// its push), then through one back-end update into the result register. The back
// end stalls only on the result register; the queue of QUEUE_DEPTH requests absorbs
// that stall before full rises.
// Reset is asynchronous, active low, and leaves both sides empty.
module canopen_frame_dispatch_heartbeat import cfd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          operation_i,
  input  logic [10:0]         can_id_i,
  input  logic [3:0]          dlc_i,
  input  logic [31:0]         payload_i,
  input  logic [7:0]          command_i,
  input  logic [6:0]          target_node_i,
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  velocity_setpoint_o,
  output logic [6:0]          node_mode_o,
  output logic [15:0]         emergency_code_o,
  output logic [7:0]          fault_flags_o,
  output logic                heartbeat_timeout_o,
  output logic                frame_rejected_o,
  output logic                tx_valid_o,
  output logic [10:0]         tx_can_id_o,
  output logic [7:0]          tx_byte0_o,
  output logic [7:0]          tx_byte1_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t     cfg_q;
  cfg_idx_e cfg_idx;
  logic     cfg_wr;
  item_t    front_item, queue_item;
  logic     queue_empty, queue_pop;
  result_t  res;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable   <= 1'b0;
      cfg_q.own_node <= NODE_RST;
      cfg_q.timeout  <= TIMEOUT_RST;
      cfg_q.period   <= PERIOD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_ENABLE:   cfg_q.enable   <= pwdata[0];
        CFG_OWN_NODE: cfg_q.own_node <= pwdata[6:0];
        CFG_TIMEOUT:  cfg_q.timeout  <= pwdata[15:0];
        CFG_PERIOD:   cfg_q.period   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_ENABLE:   prdata = {31'd0, cfg_q.enable};
      CFG_OWN_NODE: prdata = {25'd0, cfg_q.own_node};
      CFG_TIMEOUT:  prdata = {16'd0, cfg_q.timeout};
      CFG_PERIOD:   prdata = {16'd0, cfg_q.period};
      default:      prdata = '0;
    endcase
  end

  cfd_front u_front (
    .enable_i      (cfg_q.enable),
    .operation_i   (operation_i),
    .can_id_i      (can_id_i),
    .dlc_i         (dlc_i),
    .payload_i     (payload_i),
    .command_i     (command_i),
    .target_node_i (target_node_i),
    .item_o        (front_item)
  );

  cfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (queue_pop),
    .data_o  (queue_item),
    .empty_o (queue_empty)
  );

  cfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (queue_item),
    .item_empty_i (queue_empty),
    .item_pop_o   (queue_pop),
    .res_o        (res),
    .res_empty_o  (empty),
    .res_pop_i    (pop)
  );

  assign velocity_setpoint_o = res.velocity_setpoint;
  assign node_mode_o         = res.node_mode;
  assign emergency_code_o    = res.emergency_code;
  assign fault_flags_o       = res.fault_flags;
  assign heartbeat_timeout_o = res.heartbeat_timeout;
  assign frame_rejected_o    = res.frame_rejected;
  assign tx_valid_o          = res.tx_valid;
  assign tx_can_id_o         = res.tx_can_id;
  assign tx_byte0_o          = res.tx_byte0;
  assign tx_byte1_o          = res.tx_byte1;

endmodule
